// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the datagram parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DPV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("datagram parser check failed");

// Next-cycle implication, disabled while reset is low.
`define DPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("datagram parser check failed");

`endif

// ===== sv/dpv_pkg.sv =====
// Shared types and constants of the datagram parser.
// No dependencies.
`default_nettype none

package dpv_pkg;

  localparam int HdrBytes = 14;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_LEN_MISM = 2'd3
  } status_e;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  payload;
    logic        eod;
    status_e     status;
    logic        csum_ok;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] declared_len;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/dpv_parser.sv =====
// Per-word header capture, payload forwarding, checksum accumulation and end-of-datagram summary.
// Depends on dpv_pkg.
`default_nettype none

module dpv_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic             take_i,
  output logic                  emit_o,
  output dpv_pkg::result_t      res_o
);

  localparam logic [15:0] MaxPay   = 16'(MAX_PAYLOAD);
  localparam logic [15:0] HdrLen16 = 16'(dpv_pkg::HdrBytes);
  localparam logic [15:0] CntMax   = 16'hFFFF;

  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  type_q, type_n;
  logic [7:0]  flags_q, flags_n;
  logic [31:0] seq_q, seq_n;
  logic [31:0] ack_q, ack_n;
  logic [15:0] len_q, len_n;
  logic [15:0] csum_q, csum_n;
  logic [31:0] sum_q, sum_n;

  logic [16:0] addend;
  logic        fwd;
  logic [15:0] pay_idx;
  logic [16:0] total;
  logic [16:0] exp_total;
  logic [15:0] folded;
  logic        short_hdr;
  dpv_pkg::status_e status;

  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return s2[15:0];
  endfunction

  assign pay_idx = cnt_q - HdrLen16;

  always_comb begin
    type_n  = type_q;
    flags_n = flags_q;
    seq_n   = seq_q;
    ack_n   = ack_q;
    len_n   = len_q;
    csum_n  = csum_q;
    addend  = '0;
    fwd     = 1'b0;
    if (cnt_q < HdrLen16) begin
      if (cnt_q == 16'd0) begin
        type_n = byte_i;
        addend = {9'd0, byte_i};
      end else if (cnt_q == 16'd1) begin
        flags_n = byte_i;
        addend  = {9'd0, byte_i};
      end else if (cnt_q inside {[16'd2:16'd5]}) begin
        seq_n = {seq_q[23:0], byte_i};
        if (cnt_q == 16'd5) begin
          addend = {1'b0, seq_n[15:0]} + {1'b0, seq_n[31:16]};
        end
      end else if (cnt_q inside {[16'd6:16'd9]}) begin
        ack_n = {ack_q[23:0], byte_i};
        if (cnt_q == 16'd9) begin
          addend = {1'b0, ack_n[15:0]} + {1'b0, ack_n[31:16]};
        end
      end else if (cnt_q inside {[16'd10:16'd11]}) begin
        len_n = {len_q[7:0], byte_i};
        if (cnt_q == 16'd11) begin
          addend = {1'b0, len_n};
        end
      end else begin
        csum_n = {csum_q[7:0], byte_i};
      end
    end else if (cnt_q != CntMax && pay_idx < MaxPay) begin
      fwd    = 1'b1;
      addend = {9'd0, byte_i};
    end
  end

  assign sum_n = sum_q + {15'd0, addend};
  assign cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + 16'd1;

  // Summary of the datagram, valid on its last word.
  assign total     = {1'b0, cnt_q} + 17'd1;
  assign exp_total = {1'b0, HdrLen16} + {1'b0, len_n};
  assign short_hdr = total < {1'b0, HdrLen16};
  assign folded    = fold16(sum_n);

  always_comb begin
    if (short_hdr) begin
      status = dpv_pkg::ST_SHORT;
    end else if (len_n > MaxPay) begin
      status = dpv_pkg::ST_TOO_BIG;
    end else if (cnt_q == CntMax || total != exp_total) begin
      status = dpv_pkg::ST_LEN_MISM;
    end else begin
      status = dpv_pkg::ST_OK;
    end
  end

  assign emit_o = fwd | last_i;

  always_comb begin
    res_o          = '0;
    res_o.has_byte = fwd;
    res_o.payload  = fwd ? byte_i : 8'd0;
    if (last_i) begin
      res_o.eod     = 1'b1;
      res_o.status  = status;
      res_o.csum_ok = (status == dpv_pkg::ST_OK) && ((~folded) == csum_n);
      if (!short_hdr) begin
        res_o.pkt_type     = type_n;
        res_o.pkt_flags    = flags_n;
        res_o.seq_num      = seq_n;
        res_o.ack_num      = ack_n;
        res_o.declared_len = len_n;
      end
    end
  end

  // Clear all datagram state after its last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      type_q  <= '0;
      flags_q <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
      len_q   <= '0;
      csum_q  <= '0;
      sum_q   <= '0;
    end else if (take_i) begin
      if (last_i) begin
        cnt_q   <= '0;
        type_q  <= '0;
        flags_q <= '0;
        seq_q   <= '0;
        ack_q   <= '0;
        len_q   <= '0;
        csum_q  <= '0;
        sum_q   <= '0;
      end else begin
        cnt_q   <= cnt_d;
        type_q  <= type_n;
        flags_q <= flags_n;
        seq_q   <= seq_n;
        ack_q   <= ack_n;
        len_q   <= len_n;
        csum_q  <= csum_n;
        sum_q   <= sum_n;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/datagram_parse_and_verify.sv =====
// Datagram receive parser: header capture, payload forwarding and checksum check.
// Depends on dpv_pkg and dpv_parser.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one datagram word per item:
//   rx_byte_i plus is_last_i on the final word. The first 14 words form the
//   big-endian header; later words are payload.
//   Output channel (out_valid_o / out_stall_i) carries a result for each
//   forwarded payload word (has_byte_o) and for each final word
//   (end_of_datagram_o with status, checksum flag and header fields).
//   Header words that are not final produce no result.
// Timing:
//   A word accepted into the input register is processed out of it, and its
//   result lands in the output register, from which it is offered.
//   Throughput is one word per clock with no stall.
// Stall:
//   A stalled result holds in the output register; the input register still
//   drains words that produce no result, and stalls only when a word with a
//   result finds the output full.
// Reset:
//   rst_ni clears both registers' valid flags and all datagram state; the
//   first word after reset is header byte 0.
`default_nettype none

module datagram_parse_and_verify #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             has_byte_o,
  output logic [7:0]       payload_out_o,
  output logic             end_of_datagram_o,
  output logic [1:0]       status_o,
  output logic             checksum_ok_o,
  output logic [7:0]       pkt_type_o,
  output logic [7:0]       pkt_flags_o,
  output logic [31:0]      seq_num_o,
  output logic [31:0]      ack_num_o,
  output logic [15:0]      declared_len_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Output register
  logic              out_valid_q;
  dpv_pkg::result_t  out_res_q;

  logic              emit;
  logic              take;
  logic              out_free;
  logic              in_accept;
  dpv_pkg::result_t  res;

  dpv_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .take_i (take),
    .emit_o (emit),
    .res_o  (res)
  );

  // Advance the held word when it has no result or the output can take one.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign take      = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !take;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign has_byte_o        = out_res_q.has_byte;
  assign payload_out_o     = out_res_q.payload;
  assign end_of_datagram_o = out_res_q.eod;
  assign status_o          = out_res_q.status;
  assign checksum_ok_o     = out_res_q.csum_ok;
  assign pkt_type_o        = out_res_q.pkt_type;
  assign pkt_flags_o       = out_res_q.pkt_flags;
  assign seq_num_o         = out_res_q.seq_num;
  assign ack_num_o         = out_res_q.ack_num;
  assign declared_len_o    = out_res_q.declared_len;

endmodule

`default_nettype wire

// ===== sv/dpv_checker.sv =====
// Port-level checks of the datagram parser, bound to its top level.
// Depends on assert_macros.svh and dpv_pkg.
`default_nettype none

`include "assert_macros.svh"

module dpv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        has_byte_o,
  input wire logic [7:0]  payload_out_o,
  input wire logic        end_of_datagram_o,
  input wire logic [1:0]  status_o,
  input wire logic        checksum_ok_o,
  input wire logic [31:0] seq_num_o,
  input wire logic [31:0] ack_num_o,
  input wire logic [15:0] declared_len_o
);

  logic st_ok;
  logic st_short;

  assign st_ok    = status_o == dpv_pkg::ST_OK;
  assign st_short = status_o == dpv_pkg::ST_SHORT;

  `DPV_ASSERT_NOW(a_payload_zero, clk_i, rst_ni, out_valid_o && !has_byte_o, payload_out_o == 8'd0)
  `DPV_ASSERT_NOW(a_mid_summary_zero, clk_i, rst_ni, out_valid_o && !end_of_datagram_o, st_ok && !checksum_ok_o && declared_len_o == 16'd0)
  `DPV_ASSERT_NOW(a_csum_needs_ok, clk_i, rst_ni, out_valid_o && checksum_ok_o, st_ok && end_of_datagram_o)
  `DPV_ASSERT_NOW(a_short_no_hdr, clk_i, rst_ni, out_valid_o && end_of_datagram_o && st_short, seq_num_o == 32'd0 && ack_num_o == 32'd0 && declared_len_o == 16'd0)
  `DPV_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(payload_out_o) && $stable(status_o))

endmodule

bind datagram_parse_and_verify dpv_checker u_dpv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .has_byte_o        (has_byte_o),
  .payload_out_o     (payload_out_o),
  .end_of_datagram_o (end_of_datagram_o),
  .status_o          (status_o),
  .checksum_ok_o     (checksum_ok_o),
  .seq_num_o         (seq_num_o),
  .ack_num_o         (ack_num_o),
  .declared_len_o    (declared_len_o)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for datagram_parse_and_verify: drives datagram words with
// random gaps and output stalls, predicts every result and compares it field by field.
// Depends on dpv_pkg and the datagram_parse_and_verify RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPayload = 1024;
  // Least number of words to send over the whole run.
  localparam int unsigned ItemTarget = 1800;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HangLimit = 4000;
  // Cycles to wait after the last expected result for anything stray.
  localparam int DrainCycles = 8;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        has_byte_o;
  logic [7:0]  payload_out_o;
  logic        end_of_datagram_o;
  logic [1:0]  status_o;
  logic        checksum_ok_o;
  logic [7:0]  pkt_type_o;
  logic [7:0]  pkt_flags_o;
  logic [31:0] seq_num_o;
  logic [31:0] ack_num_o;
  logic [15:0] declared_len_o;

  datagram_parse_and_verify #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .has_byte_o       (has_byte_o),
    .payload_out_o    (payload_out_o),
    .end_of_datagram_o(end_of_datagram_o),
    .status_o         (status_o),
    .checksum_ok_o    (checksum_ok_o),
    .pkt_type_o       (pkt_type_o),
    .pkt_flags_o      (pkt_flags_o),
    .seq_num_o        (seq_num_o),
    .ack_num_o        (ack_num_o),
    .declared_len_o   (declared_len_o)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Run-wide bookkeeping
  // ---------------------------------------------------------------------------
  bit          quiet = 1'b0;      // set to suppress all idling on both sides
  int          mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned datagrams_seen = 0;
  int unsigned forwarded_seen = 0;
  int unsigned csum_pass_seen = 0;
  int unsigned status_hits[4];

  // Results still owed by the block, oldest first.
  dpv_pkg::result_t report_q[$];
  // Datagram currently being assembled for transmission.
  logic [7:0] frame_q[$];

  // ---------------------------------------------------------------------------
  // Parser shadow: its own copy of the per-datagram state
  // ---------------------------------------------------------------------------
  int unsigned rx_count;
  logic [7:0]  cap_type;
  logic [7:0]  cap_flags;
  logic [31:0] cap_seq;
  logic [31:0] cap_ack;
  logic [15:0] cap_len;
  logic [15:0] cap_csum;
  logic [31:0] csum_acc;

  function automatic void clear_shadow();
    rx_count  = 0;
    cap_type  = '0;
    cap_flags = '0;
    cap_seq   = '0;
    cap_ack   = '0;
    cap_len   = '0;
    cap_csum  = '0;
    csum_acc  = '0;
  endfunction

  // Fold the 32-bit accumulator into 16 bits, end-around carry.
  function automatic logic [15:0] fold_carries(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int k = 0; k < 3; k++) v = {16'h0, v[15:0]} + {16'h0, v[31:16]};
    return v[15:0];
  endfunction

  // Advance the shadow by one accepted word and queue the result it owes, if any.
  function automatic void track_byte(input logic [7:0] b, input logic last);
    int unsigned      idx;
    bit               fwd;
    dpv_pkg::result_t r;
    idx = rx_count;
    fwd = 1'b0;
    r   = '0;
    if (idx < dpv_pkg::HdrBytes) begin
      if (idx == 0) begin
        cap_type = b;
        csum_acc += {24'h0, b};
      end else if (idx == 1) begin
        cap_flags = b;
        csum_acc += {24'h0, b};
      end else if (idx <= 5) begin
        cap_seq = {cap_seq[23:0], b};
        if (idx == 5) csum_acc += {16'h0, cap_seq[15:0]} + {16'h0, cap_seq[31:16]};
      end else if (idx <= 9) begin
        cap_ack = {cap_ack[23:0], b};
        if (idx == 9) csum_acc += {16'h0, cap_ack[15:0]} + {16'h0, cap_ack[31:16]};
      end else if (idx <= 11) begin
        cap_len = {cap_len[7:0], b};
        if (idx == 11) csum_acc += {16'h0, cap_len};
      end else begin
        cap_csum = {cap_csum[7:0], b};
      end
    end else if (idx < 32'hFFFF && (idx - dpv_pkg::HdrBytes) < MaxPayload) begin
      // Forward only within the payload budget and before the count saturates.
      fwd = 1'b1;
      csum_acc += {24'h0, b};
    end

    if (rx_count < 32'hFFFF) rx_count++;

    if (!fwd && !last) return;

    if (fwd) begin
      r.has_byte = 1'b1;
      r.payload  = b;
    end
    if (last) begin
      r.eod = 1'b1;
      if (idx + 1 < dpv_pkg::HdrBytes) begin
        // Header never completed: fields stay zero.
        r.status = dpv_pkg::ST_SHORT;
      end else begin
        if (cap_len > MaxPayload) r.status = dpv_pkg::ST_TOO_BIG;
        else if (idx >= 32'hFFFF || idx + 1 != dpv_pkg::HdrBytes + cap_len)
          r.status = dpv_pkg::ST_LEN_MISM;
        else r.status = dpv_pkg::ST_OK;
        r.pkt_type     = cap_type;
        r.pkt_flags    = cap_flags;
        r.seq_num      = cap_seq;
        r.ack_num      = cap_ack;
        r.declared_len = cap_len;
      end
      r.csum_ok = (r.status == dpv_pkg::ST_OK) && (~fold_carries(csum_acc) == cap_csum);
      clear_shadow();
    end
    report_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then update the shadow.
  task automatic send_word(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    is_last  <= last;
    do @(posedge clk); while (in_stall_o);
    words_sent++;
    track_byte(b, last);
  endtask

  // Assemble a datagram into frame_q; a good checksum covers the header and the
  // payload bytes that the block will sum.
  task automatic build_frame(input logic [7:0] ty, input logic [7:0] fl,
                             input logic [31:0] sq, input logic [31:0] ak,
                             input logic [15:0] len, input int unsigned n_pay,
                             input bit good_csum);
    logic [7:0]  pay_q[$];
    logic [31:0] sum;
    logic [15:0] csum;
    pay_q.delete();
    sum = {24'h0, ty} + {24'h0, fl} + {16'h0, sq[15:0]} + {16'h0, sq[31:16]}
        + {16'h0, ak[15:0]} + {16'h0, ak[31:16]} + {16'h0, len};
    for (int unsigned i = 0; i < n_pay; i++) begin
      pay_q.push_back(8'($urandom_range(0, 255)));
      if (i < MaxPayload) sum += {24'h0, pay_q[i]};
    end
    csum = ~fold_carries(sum);
    if (!good_csum) csum ^= 16'($urandom_range(1, 16'hFFFF));
    frame_q = {ty, fl, sq[31:24], sq[23:16], sq[15:8], sq[7:0],
               ak[31:24], ak[23:16], ak[15:8], ak[7:0],
               len[15:8], len[7:0], csum[15:8], csum[7:0]};
    foreach (pay_q[i]) frame_q.push_back(pay_q[i]);
  endtask

  // Drop trailing words so only the first n remain.
  task automatic cut_frame(input int unsigned n);
    while (frame_q.size() > n) frame_q.delete(frame_q.size() - 1);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Mostly well-formed datagrams with random content, plus broken ones.
  task automatic send_random_datagram();
    int unsigned pick;
    int unsigned n_pay;
    logic [15:0] len;
    pick  = $urandom_range(0, 99);
    // Keep payloads short; the payload limit has its own directed test.
    n_pay = $urandom_range(0, 24);
    len   = 16'(n_pay);
    if (pick >= 72 && pick < 84) begin
      if ($urandom_range(0, 1) || n_pay == 0) len = 16'(n_pay + $urandom_range(1, 8));
      else len = 16'($urandom_range(0, n_pay - 1));
    end else if (pick >= 92) begin
      len = 16'($urandom_range(MaxPayload + 1, 16'hFFFF));
    end
    build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom(),
                $urandom(), len, n_pay, !(pick >= 60 && pick < 72));
    if (pick >= 84 && pick < 92) cut_frame($urandom_range(1, dpv_pkg::HdrBytes - 1));
    send_frame();
  endtask

  // Output side: stall at random unless quiet.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 32);
  end

  // ---------------------------------------------------------------------------
  // Result checking: compare every accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    dpv_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("unexpected result: has_byte %0b payload 0x%0h eod %0b",
               has_byte_o, payload_out_o, end_of_datagram_o);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        check_field("has_byte", want.has_byte, has_byte_o);
        check_field("payload_out", want.payload, payload_out_o);
        check_field("end_of_datagram", want.eod, end_of_datagram_o);
        check_field("status", want.status, status_o);
        check_field("checksum_ok", want.csum_ok, checksum_ok_o);
        check_field("pkt_type", want.pkt_type, pkt_type_o);
        check_field("pkt_flags", want.pkt_flags, pkt_flags_o);
        check_field("seq_num", want.seq_num, seq_num_o);
        check_field("ack_num", want.ack_num, ack_num_o);
        check_field("declared_len", want.declared_len, declared_len_o);
        if (want.has_byte) forwarded_seen++;
        if (want.eod) begin
          datagrams_seen++;
          status_hits[want.status]++;
          if (want.csum_ok) csum_pass_seen++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  int unsigned hung_cycles = 0;
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) hung_cycles <= 0;
      else hung_cycles <= hung_cycles + 1;
      if (hung_cycles == HangLimit) begin
        $display("datagram_parse_and_verify verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Datagrams that end inside the header, including a single word.
  task automatic test_short_header();
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h00};
    send_frame();
    build_frame(8'hA5, 8'h5A, 32'hFFFF_FFFF, 32'h0, 16'd0, 0, 1'b1);
    cut_frame(dpv_pkg::HdrBytes - 1);
    send_frame();
    build_frame(8'h12, 8'h34, 32'h0123_4567, 32'h89AB_CDEF, 16'd3, 3, 1'b1);
    cut_frame(7);
    send_frame();
  endtask

  // Well-formed datagrams at the field extremes with a correct checksum.
  task automatic test_clean_datagrams();
    build_frame(8'h00, 8'h00, 32'h0, 32'h0, 16'd0, 0, 1'b1);
    send_frame();
    build_frame(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 0, 1'b1);
    send_frame();
    build_frame(8'h80, 8'h01, 32'h8000_0001, 32'h7FFF_FFFE, 16'd1, 1, 1'b1);
    send_frame();
    build_frame(8'h3C, 8'hC3, $urandom(), $urandom(), 16'd24, 24, 1'b1);
    send_frame();
  endtask

  // Correct length, wrong checksum.
  task automatic test_bad_checksum();
    build_frame(8'h11, 8'h22, $urandom(), $urandom(), 16'd0, 0, 1'b0);
    send_frame();
    build_frame(8'hFE, 8'hEF, $urandom(), $urandom(), 16'd9, 9, 1'b0);
    send_frame();
  endtask

  // Declared length over the limit.
  task automatic test_oversize_declared();
    build_frame(8'h03, 8'h04, $urandom(), $urandom(), 16'hFFFF, 3, 1'b1);
    send_frame();
    build_frame(8'h05, 8'h06, $urandom(), $urandom(), 16'(MaxPayload + 1), 2, 1'b1);
    send_frame();
  endtask

  // Actual length differs from the declared one, in both directions.
  task automatic test_length_mismatch();
    build_frame(8'h21, 8'h43, $urandom(), $urandom(), 16'd5, 3, 1'b1);
    send_frame();
    build_frame(8'h65, 8'h87, $urandom(), $urandom(), 16'd5, 8, 1'b1);
    send_frame();
    // Payload runs past the forwarding budget; extra words are neither
    // forwarded nor summed.
    build_frame(8'hA9, 8'hCB, $urandom(), $urandom(), 16'd10, MaxPayload + 6, 1'b1);
    send_frame();
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (10) send_random_datagram();
    quiet = 1'b0;
  endtask

  // Fill the rest of the word budget with random datagrams.
  task automatic test_random_traffic();
    while (words_sent < ItemTarget) send_random_datagram();
  endtask

  initial begin
    clear_shadow();
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    test_short_header();
    test_clean_datagrams();
    test_bad_checksum();
    test_oversize_declared();
    test_length_mismatch();
    test_back_to_back();
    test_random_traffic();
    in_valid <= 1'b0;

    // Wait for every owed result, then give stray results a chance to show.
    while (report_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d words in %0d datagrams, %0d payload words forwarded.",
             words_sent, datagrams_seen, forwarded_seen);
    $display("Status ok/short/too-big/mismatch: %0d/%0d/%0d/%0d, checksum passes: %0d.",
             status_hits[dpv_pkg::ST_OK], status_hits[dpv_pkg::ST_SHORT],
             status_hits[dpv_pkg::ST_TOO_BIG], status_hits[dpv_pkg::ST_LEN_MISM],
             csum_pass_seen);
    if (mismatches == 0) begin
      $display("datagram_parse_and_verify verification clean");
    end else begin
      $display("datagram_parse_and_verify verification failed");
    end
    $finish;
  end

endmodule
